/* rtl/intel_hex_record_encoder_macros.svh */
// ----------------------------------------------------------------------------
// Intel HEX record encoder assertion macros
// Short forms for the concurrent checks on the encoder ports.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_ENCODER_MACROS_SVH
`define INTEL_HEX_RECORD_ENCODER_MACROS_SVH

// Checks a consequence in the same cycle as its antecedent.
`define IHEX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ihex_pkg.sv */
// ----------------------------------------------------------------------------
// Intel HEX record encoder package
// Shared sizes, codes, beat types and the hex digit function.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam int RECORD_BYTES = 16;

  localparam int CNT_W   = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W   = $clog2(RECORD_BYTES + 5);
  localparam int RAM_AW  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  typedef logic [7:0]        byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RAM_AW-1:0] ram_addr_t;

  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_ADDR = 2'd1;
  localparam logic [1:0] OP_EOF  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_NL    = 7'h0A;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h41;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  value;
    logic [15:0] address;
  } in_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last_of_run;
  } out_t;

  // One record handed to the character sequencer.
  typedef struct packed {
    cnt_t        cnt;
    logic [15:0] addr;
    logic        eof;
    byte_t       csum;
    logic        last;
    logic        eof_after;
  } rec_t;

  // End record: count 0, address FFFF, type 01. Its checksum is
  // -(FF + FF + 01) mod 256, which is 01.
  localparam rec_t EOF_REC = '{cnt: '0, addr: 16'hFFFF, eof: 1'b1, csum: 8'h01,
                               last: 1'b1, eof_after: 1'b0};

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      return CH_ZERO + wide;
    end
    return CH_A + wide - 7'd10;
  endfunction

endpackage

/* rtl/ihex_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ihex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ihex_emit.sv */
// ----------------------------------------------------------------------------
// Intel HEX record character sequencer
// Walks one record field by field and sends one ASCII character per beat.
// ----------------------------------------------------------------------------
module ihex_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ihex_pkg::rec_t     start_rec,
  output logic               busy,
  output ihex_pkg::ram_addr_t rd_addr,
  input  ihex_pkg::byte_t    rd_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ihex_pkg::out_t     out_data
);
  import ihex_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_COLON = 2'd1;
  localparam logic [1:0] PH_BYTE  = 2'd2;
  localparam logic [1:0] PH_NL    = 2'd3;

  localparam idx_t IDX_DATA0 = idx_t'(4);

  logic [1:0] phase_r, phase_nxt;
  idx_t       idx_r, idx_nxt;
  logic       half_r, half_nxt;
  rec_t       rec_r, rec_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_t       out_data_r, out_data_nxt;

  logic       adv;
  idx_t       csum_idx;
  idx_t       csum_idx_nxt;
  byte_t      byte_cur;
  logic [3:0] nib;

  assign adv          = !out_valid_r || !out_stall;
  assign csum_idx     = idx_t'(rec_r.cnt) + IDX_DATA0;
  assign csum_idx_nxt = idx_t'(rec_nxt.cnt) + IDX_DATA0;

  // Byte list: count, address high, address low, type, data, checksum.
  always_comb begin
    if (idx_r == idx_t'(0)) begin
      byte_cur = byte_t'(rec_r.cnt);
    end else if (idx_r == idx_t'(1)) begin
      byte_cur = rec_r.addr[15:8];
    end else if (idx_r == idx_t'(2)) begin
      byte_cur = rec_r.addr[7:0];
    end else if (idx_r == idx_t'(3)) begin
      byte_cur = {7'b0000000, rec_r.eof};
    end else if (idx_r == csum_idx) begin
      byte_cur = rec_r.csum;
    end else begin
      byte_cur = rd_data;
    end
  end

  assign nib = half_r ? byte_cur[3:0] : byte_cur[7:4];

  always_comb begin
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    half_nxt      = half_r;
    rec_nxt       = rec_r;
    out_valid_nxt = adv ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          rec_nxt   = start_rec;
          phase_nxt = PH_COLON;
          idx_nxt   = '0;
          half_nxt  = 1'b0;
        end
      end
      PH_COLON: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{character: CH_COLON, last_of_run: 1'b0};
          phase_nxt     = PH_BYTE;
          idx_nxt       = '0;
          half_nxt      = 1'b0;
        end
      end
      PH_BYTE: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{character: hex_char(nib), last_of_run: 1'b0};
          if (!half_r) begin
            half_nxt = 1'b1;
          end else if (idx_r == csum_idx) begin
            phase_nxt = PH_NL;
          end else begin
            idx_nxt  = idx_r + idx_t'(1);
            half_nxt = 1'b0;
          end
        end
      end
      PH_NL: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{character: CH_NL, last_of_run: rec_r.last};
          if (rec_r.eof_after) begin
            rec_nxt   = EOF_REC;
            phase_nxt = PH_COLON;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // The read address follows the next byte index, so the registered read
  // data lines up with the byte that is current in the following cycle.
  always_comb begin
    if (idx_nxt >= IDX_DATA0 && idx_nxt < csum_idx_nxt) begin
      rd_addr = ram_addr_t'(idx_nxt - IDX_DATA0);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    half_r     <= half_nxt;
    rec_r      <= rec_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (phase_r != PH_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/intel_hex_record_encoder.sv */
// ----------------------------------------------------------------------------
// Intel HEX record encoder
// A record's first character passes the phase and output registers after its
// item. Data bytes that fill no record are taken one per cycle while idle; a
// record stalls the input, one character per cycle unless out_stall is set.
// ----------------------------------------------------------------------------
module intel_hex_record_encoder (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ihex_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ihex_pkg::out_t out_data
);
  import ihex_pkg::*;

  // Reset clears the byte count, address and sum; buffer contents are kept.
  localparam byte_t RB8 = byte_t'(RECORD_BYTES);

  cnt_t        cnt_r, cnt_nxt;
  logic [15:0] addr_r, addr_nxt;
  byte_t       sum_r, sum_nxt;

  logic        busy;
  logic        accept;
  logic        start;
  rec_t        start_rec;
  logic        ram_we;
  ram_addr_t   rd_addr;
  byte_t       rd_data;
  cnt_t        cnt_inc;
  byte_t       sum_add;
  logic [15:0] base_nxt;

  assign accept  = in_valid && !busy;
  assign in_stall = busy;
  assign ram_we  = accept && (in_data.operation == OP_DATA);
  assign cnt_inc = cnt_r + cnt_t'(1);
  assign sum_add = sum_r + in_data.value;

  always_comb begin
    cnt_nxt   = cnt_r;
    addr_nxt  = addr_r;
    sum_nxt   = sum_r;
    start     = 1'b0;
    start_rec = EOF_REC;
    base_nxt  = addr_r;
    if (accept) begin
      case (in_data.operation)
        OP_DATA: begin
          if (cnt_inc == cnt_t'(RECORD_BYTES)) begin
            start     = 1'b1;
            start_rec = '{cnt: cnt_t'(RECORD_BYTES), addr: addr_r, eof: 1'b0,
                          csum: byte_t'(8'd0 - (sum_add + RB8)),
                          last: 1'b1, eof_after: 1'b0};
            base_nxt  = addr_r + 16'(RECORD_BYTES);
            addr_nxt  = base_nxt;
            sum_nxt   = base_nxt[15:8] + base_nxt[7:0];
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
            sum_nxt = sum_add;
          end
        end
        OP_ADDR: begin
          if (cnt_r != '0) begin
            start     = 1'b1;
            start_rec = '{cnt: cnt_r, addr: addr_r, eof: 1'b0,
                          csum: byte_t'(8'd0 - (sum_r + byte_t'(cnt_r))),
                          last: 1'b1, eof_after: 1'b0};
          end
          addr_nxt = in_data.address;
          sum_nxt  = in_data.address[15:8] + in_data.address[7:0];
          cnt_nxt  = '0;
        end
        OP_EOF: begin
          start = 1'b1;
          // A partial record goes out first and chains into the end record.
          if (cnt_r != '0) begin
            start_rec = '{cnt: cnt_r, addr: addr_r, eof: 1'b0,
                          csum: byte_t'(8'd0 - (sum_r + byte_t'(cnt_r))),
                          last: 1'b0, eof_after: 1'b1};
          end
          addr_nxt = 16'hFFFF;
          sum_nxt  = 8'hFE;
          cnt_nxt  = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      addr_r <= '0;
      sum_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      addr_r <= addr_nxt;
      sum_r  <= sum_nxt;
    end
  end

  ihex_ram #(
    .WIDTH (8),
    .DEPTH (RECORD_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr_t'(cnt_r)),
    .wdata (in_data.value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ihex_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .start_rec (start_rec),
    .busy      (busy),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/ihex_chk.sv */
// ----------------------------------------------------------------------------
// Intel HEX record encoder port checker
// Watches the encoder ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "intel_hex_record_encoder_macros.svh"

module ihex_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input ihex_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input ihex_pkg::out_t out_data
);
  import ihex_pkg::*;

  logic in_acc;
  logic out_held;

  assign in_acc   = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;

  `IHEX_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "held beat changed")
  `IHEX_ASSERT_NOW(a_last_is_nl, out_valid && out_data.last_of_run, out_data.character == CH_NL, "no newline")
  `IHEX_ASSERT_NEXT(a_eof_busy, in_acc && in_data.operation == OP_EOF, in_stall, "end not started")
  `IHEX_ASSERT_NEXT(a_nop_idle, in_acc && in_data.operation == OP_NONE, !in_stall, "unused code busy")

endmodule

bind intel_hex_record_encoder ihex_chk u_chk (.*);
